FILE: hdl/ibt_pkg.sv
package ibt_pkg;

    // Field widths of the token records
    localparam int OFFSET_BITS   = 20;
    localparam int POSITION_BITS = 16;

    // Results one source beat can cause
    localparam int RUN_DEPTH = 3;

    typedef enum logic
    {
        REC_TOKEN = 1'b0,
        REC_ERROR = 1'b1
    } rec_kind_t;

    typedef enum logic [2:0]
    {
        TK_EQUAL  = 3'd0,
        TK_LBRACK = 3'd1,
        TK_RBRACK = 3'd2,
        TK_EOL    = 3'd3,
        TK_IDENT  = 3'd4,
        TK_STRING = 3'd5,
        TK_EOF    = 3'd6
    } tok_kind_t;

    typedef enum logic [1:0]
    {
        ERR_NONE         = 2'd0,
        ERR_UNEXPECTED   = 2'd1,
        ERR_UNTERMINATED = 2'd2
    } err_kind_t;

    typedef struct packed
    {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_source;
    } in_item_t;

    typedef struct packed
    {
        rec_kind_t                record_kind;
        tok_kind_t                token_kind;
        err_kind_t                error_kind;
        logic [OFFSET_BITS-1:0]   start_offset;
        logic [OFFSET_BITS-1:0]   lexeme_length;
        logic [POSITION_BITS-1:0] line_number;
        logic [POSITION_BITS-1:0] column_number;
        logic                     last_of_run;
    } out_item_t;

    // All records caused by one source beat, oldest in slot 0
    typedef struct packed
    {
        logic [1:0]                    count;
        out_item_t [RUN_DEPTH-1:0]     rec;
    } run_t;

endpackage

FILE: hdl/ibt_lexer.sv
module ibt_lexer
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  ibt_pkg::in_item_t item,
    output ibt_pkg::run_t    run
);
    import ibt_pkg::*;

    typedef enum logic [1:0]
    {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_QUOTED,
        MODE_WORD
    } mode_t;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DIG_LO = 8'h30;
    localparam logic [7:0] CH_DIG_HI = 8'h39;
    localparam logic [7:0] CH_LOW_LO = 8'h61;
    localparam logic [7:0] CH_LOW_HI = 8'h7A;
    localparam logic [7:0] CH_UP_LO  = 8'h41;
    localparam logic [7:0] CH_UP_HI  = 8'h5A;

    mode_t                    mode_reg, mode_next;
    logic                     aa_reg, aa_next;
    logic [OFFSET_BITS-1:0]   off_reg, off_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic [OFFSET_BITS-1:0]   tok_off_reg, tok_off_next;
    logic [POSITION_BITS-1:0] tok_line_reg, tok_line_next;
    logic [POSITION_BITS-1:0] tok_col_reg, tok_col_next;
    logic [POSITION_BITS-1:0] last_col_reg, last_col_next;
    logic                     seen_reg, seen_next;

    function automatic logic is_alnum(input logic [7:0] b);
        return (b >= CH_DIG_LO && b <= CH_DIG_HI) ||
               (b >= CH_LOW_LO && b <= CH_LOW_HI) ||
               (b >= CH_UP_LO && b <= CH_UP_HI);
    endfunction

    function automatic logic [OFFSET_BITS-1:0] off_inc(input logic [OFFSET_BITS-1:0] v);
        return (v == {OFFSET_BITS{1'b1}}) ? v : v + OFFSET_BITS'(1);
    endfunction

    function automatic logic [POSITION_BITS-1:0] pos_inc(
        input logic [POSITION_BITS-1:0] v
    );
        return (v == {POSITION_BITS{1'b1}}) ? v : v + POSITION_BITS'(1);
    endfunction

    function automatic out_item_t make_rec(
        input rec_kind_t                rk,
        input tok_kind_t                tk,
        input err_kind_t                ek,
        input logic [OFFSET_BITS-1:0]   o,
        input logic [OFFSET_BITS-1:0]   len,
        input logic [POSITION_BITS-1:0] ln,
        input logic [POSITION_BITS-1:0] c
    );
        out_item_t r;
        r               = '0;
        r.record_kind   = rk;
        r.token_kind    = tk;
        r.error_kind    = ek;
        r.start_offset  = o;
        r.lexeme_length = len;
        r.line_number   = ln;
        r.column_number = c;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    // Walk one beat: byte handling, then end-of-source flush
    always_comb
    begin : lex_step
        logic [7:0]               b;
        logic                     idle_go;
        logic                     cont;
        logic [OFFSET_BITS-1:0]   off0;
        logic [POSITION_BITS-1:0] line0;
        logic [POSITION_BITS-1:0] eof_col;
        logic [1:0]               n;
        out_item_t [RUN_DEPTH-1:0] recs;

        b             = item.data_byte;
        idle_go       = 1'b0;
        cont          = 1'b0;
        off0          = off_reg;
        line0         = line_reg;
        eof_col       = '0;
        n             = '0;
        recs          = '0;
        mode_next     = mode_reg;
        aa_next       = aa_reg;
        off_next      = off_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        tok_off_next  = tok_off_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        last_col_next = last_col_reg;
        seen_next     = seen_reg;

        if (item.byte_present)
        begin
            unique case (mode_reg)
                MODE_COMMENT:
                begin
                    if (b == CH_LF)
                    begin
                        mode_next = MODE_IDLE;
                        idle_go   = 1'b1;
                    end
                    else
                    begin
                        off_next = off_inc(off_next);
                        col_next = pos_inc(col_next);
                    end
                end
                MODE_QUOTED:
                begin
                    // Closing quote: content length excludes both quotes
                    if (b == CH_QUOTE)
                    begin
                        recs[n] = make_rec(REC_TOKEN, TK_STRING, ERR_NONE, tok_off_reg,
                                           off_reg - tok_off_reg, tok_line_reg, tok_col_reg);
                        n             = n + 2'd1;
                        last_col_next = tok_col_reg;
                        seen_next     = 1'b1;
                        aa_next       = 1'b1;
                        mode_next     = MODE_IDLE;
                    end
                    off_next = off_inc(off_next);
                    col_next = pos_inc(col_next);
                end
                MODE_WORD:
                begin
                    // Bare values run to CR or LF, identifiers to a non-name byte
                    cont = aa_reg ? (b != CH_CR && b != CH_LF)
                                  : (is_alnum(b) || b == CH_UNDER);
                    if (cont)
                    begin
                        off_next = off_inc(off_next);
                        col_next = pos_inc(col_next);
                    end
                    else
                    begin
                        recs[n] = make_rec(REC_TOKEN, aa_reg ? TK_STRING : TK_IDENT,
                                           ERR_NONE, tok_off_reg, off_reg - tok_off_reg,
                                           tok_line_reg, tok_col_reg);
                        n             = n + 2'd1;
                        last_col_next = tok_col_reg;
                        seen_next     = 1'b1;
                        mode_next     = MODE_IDLE;
                        idle_go       = 1'b1;
                    end
                end
                MODE_IDLE:
                begin
                    idle_go = 1'b1;
                end
            endcase

            // Idle handling, also for the byte that ended a word or comment
            if (idle_go)
            begin
                off0     = off_next;
                line0    = line_next;
                off_next = off_inc(off_next);
                col_next = pos_inc(col_next);
                unique case (b)
                    CH_SEMI, CH_HASH:
                    begin
                        mode_next = MODE_COMMENT;
                    end
                    CH_EQUAL:
                    begin
                        recs[n] = make_rec(REC_TOKEN, TK_EQUAL, ERR_NONE, off0, '0,
                                           line0, col_next);
                        n             = n + 2'd1;
                        last_col_next = col_next;
                        seen_next     = 1'b1;
                        aa_next       = 1'b1;
                    end
                    CH_QUOTE:
                    begin
                        mode_next     = MODE_QUOTED;
                        tok_off_next  = off_next;
                        tok_line_next = line0;
                        tok_col_next  = col_next;
                    end
                    CH_LF:
                    begin
                        recs[n] = make_rec(REC_TOKEN, TK_EOL, ERR_NONE, off0, '0,
                                           line0, col_next);
                        n             = n + 2'd1;
                        last_col_next = col_next;
                        seen_next     = 1'b1;
                        line_next     = pos_inc(line_next);
                        col_next      = '0;
                        aa_next       = 1'b0;
                    end
                    CH_SPACE, CH_CR, CH_TAB:
                    begin
                        cont = 1'b0;
                    end
                    CH_LBRACK:
                    begin
                        recs[n] = make_rec(REC_TOKEN, TK_LBRACK, ERR_NONE, off0, '0,
                                           line0, col_next);
                        n             = n + 2'd1;
                        last_col_next = col_next;
                        seen_next     = 1'b1;
                    end
                    CH_RBRACK:
                    begin
                        recs[n] = make_rec(REC_TOKEN, TK_RBRACK, ERR_NONE, off0, '0,
                                           line0, col_next);
                        n             = n + 2'd1;
                        last_col_next = col_next;
                        seen_next     = 1'b1;
                    end
                    default:
                    begin
                        if (is_alnum(b))
                        begin
                            mode_next     = MODE_WORD;
                            tok_off_next  = off0;
                            tok_line_next = line0;
                            tok_col_next  = col_next;
                        end
                        else
                        begin
                            recs[n] = make_rec(REC_ERROR, TK_EQUAL, ERR_UNEXPECTED, off0,
                                               '0, line0, col_next);
                            n = n + 2'd1;
                        end
                    end
                endcase
            end
        end

        // Flush a pending word or flag an unterminated string, close with eof, return to reset state
        if (item.end_of_source)
        begin
            if (mode_next == MODE_WORD)
            begin
                recs[n] = make_rec(REC_TOKEN, aa_next ? TK_STRING : TK_IDENT, ERR_NONE,
                                   tok_off_next, off_next - tok_off_next,
                                   tok_line_next, tok_col_next);
                n             = n + 2'd1;
                last_col_next = tok_col_next;
                seen_next     = 1'b1;
            end
            else if (mode_next == MODE_QUOTED)
            begin
                recs[n] = make_rec(REC_ERROR, TK_EQUAL, ERR_UNTERMINATED,
                                   tok_off_next - OFFSET_BITS'(1), '0,
                                   tok_line_next, tok_col_next);
                n = n + 2'd1;
            end
            eof_col = seen_next ? pos_inc(last_col_next) : '0;
            recs[n] = make_rec(REC_TOKEN, TK_EOF, ERR_NONE, off_next, '0,
                               line_next, eof_col);
            n             = n + 2'd1;
            mode_next     = MODE_IDLE;
            aa_next       = 1'b0;
            off_next      = '0;
            line_next     = '0;
            col_next      = '0;
            tok_off_next  = '0;
            tok_line_next = '0;
            tok_col_next  = '0;
            last_col_next = '0;
            seen_next     = 1'b0;
        end

        run.count = n;
        run.rec   = recs;
    end

    // Commit the lexer state when the beat is handed to the result buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            aa_reg       <= 1'b0;
            off_reg      <= '0;
            line_reg     <= '0;
            col_reg      <= '0;
            tok_off_reg  <= '0;
            tok_line_reg <= '0;
            tok_col_reg  <= '0;
            last_col_reg <= '0;
            seen_reg     <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg     <= mode_next;
            aa_reg       <= aa_next;
            off_reg      <= off_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            tok_off_reg  <= tok_off_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
            last_col_reg <= last_col_next;
            seen_reg     <= seen_next;
        end
    end

    // The eof token always closes the run of a final beat
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.end_of_source |->
            run.count != 2'd0 && run.rec[run.count - 2'd1].token_kind == TK_EOF)
        else $error("eof token missing at end of run");

    // A beat with neither byte nor end mark produces nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !item.byte_present && !item.end_of_source |-> run.count == 2'd0)
        else $error("empty beat produced records");

    // End of source returns the position counters to their start
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.end_of_source |=>
            mode_reg == MODE_IDLE && off_reg == '0 && line_reg == '0 && !seen_reg)
        else $error("lexer state not cleared after end of source");

endmodule

FILE: hdl/ibt_run_buffer.sv
module ibt_run_buffer
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  ibt_pkg::run_t     run,
    output logic              ready,
    output ibt_pkg::out_item_t result,
    output logic              result_valid,
    input  logic              result_stall
);
    import ibt_pkg::*;

    logic [1:0]                cnt_reg, cnt_next;
    out_item_t [RUN_DEPTH-1:0] rec_reg, rec_next;
    logic                      take;

    assign result_valid = (cnt_reg != 2'd0);
    assign take         = result_valid && !result_stall;

    // Take a new run once the current one is gone or leaves on this beat
    assign ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && take);

    // Drive the oldest record; the run ends with the last one held
    always_comb
    begin
        result             = rec_reg[0];
        result.last_of_run = (cnt_reg == 2'd1);
    end

    // Load a fresh run or shift the held one down a slot
    always_comb
    begin
        cnt_next = cnt_reg;
        rec_next = rec_reg;
        if (load)
        begin
            cnt_next = run.count;
            rec_next = run.rec;
        end
        else if (take)
        begin
            cnt_next    = cnt_reg - 2'd1;
            rec_next[0] = rec_reg[1];
            rec_next[1] = rec_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    // A taken record inside a run leaves one fewer behind
    assert property (@(posedge clk) disable iff (!rst_n)
        take && cnt_reg > 2'd1 |=> cnt_reg == $past(cnt_reg) - 2'd1)
        else $error("run count did not step down");

    // The next record of a run moves to the front after a take
    assert property (@(posedge clk) disable iff (!rst_n)
        take && cnt_reg > 2'd1 |=> rec_reg[0] == $past(rec_reg[1]))
        else $error("run records did not shift");

    // A loaded run shows all of its records
    assert property (@(posedge clk) disable iff (!rst_n)
        load && run.count != 2'd0 |=> cnt_reg == $past(run.count))
        else $error("loaded run has the wrong count");

endmodule

FILE: hdl/ini_byte_tokenizer_core.sv
// INI tokenizer core: source text goes in one byte per beat, token and
// error records come out.
// Input channel (item, item_valid, item_stall): one beat carries a byte,
// a byte-present flag and an end-of-source mark. A beat with only the end
// mark closes the text without a byte.
// Output channel (result, result_valid, result_stall): each record gives
// kind, offset, length, line and column. One input beat causes zero to
// three records; last_of_run marks the final record of that beat.
// An accepted beat is held in the input register; the lexer turns it
// into records that are registered in the result buffer and driven onto
// the port. Throughput is one input beat per cycle while each beat makes
// at most one record and the receiver does not stall; a beat with several
// records holds the port until all are taken; records leave one per cycle
// while unstalled. A beat that makes no record occupies no output.
// When the receiver stalls, the held record stays on the port, the next
// beat waits in the input register and item_stall rises once it is full.
// Reset clears the lexer to idle at line 0, column 0, offset 0, and
// empties both the input register and the result buffer. End of source
// returns the lexer to the same state after the eof token.
module ini_byte_tokenizer_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  ibt_pkg::in_item_t  item,
    input  logic               item_valid,
    output logic               item_stall,
    output ibt_pkg::out_item_t result,
    output logic               result_valid,
    input  logic               result_stall
);
    import ibt_pkg::*;

    in_item_t item_reg;
    logic     full_reg;
    logic     ready;
    logic     fire;
    run_t     run;

    // Hand the held beat to the lexer when the result buffer can take it
    assign fire       = full_reg && ready;
    assign item_stall = full_reg && !ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (item_valid && !item_stall)
        begin
            full_reg <= 1'b1;
        end
        else if (fire)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
    end

    ibt_lexer u_lexer
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .run   (run)
    );

    ibt_run_buffer u_run_buffer
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire),
        .run          (run),
        .ready        (ready),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule
